@@ hdl/mme_pkg.sv @@
// Package for the matrix multiply engine: sizes, command and register codes,
// controller/datapath struct types and the result saturation function.
// No dependencies.
package mme_pkg;

    localparam int MAX_DIM = 64;
    localparam int IDX_W   = $clog2(MAX_DIM);
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = 2 ** ADDR_W;
    localparam int CNT_W   = $clog2(MAX_DIM + 1);

    localparam int CMD_W   = 2;
    localparam int POS_W   = 6;
    localparam int VAL_W   = 16;
    localparam int CFG_W   = 7;
    localparam int CFG_IDX_W = 2;
    localparam int RES_W   = 38;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int ACC_W   = (PROD_W + IDX_W + 1 > RES_W) ? PROD_W + IDX_W + 1 : RES_W + 1;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(64);

    localparam longint RES_MAX = (64'sd1 <<< (RES_W - 1)) - 64'sd1;
    localparam longint RES_MIN = -RES_MAX - 64'sd1;
    localparam logic signed [ACC_W-1:0] ACC_HI = ACC_W'(RES_MAX);
    localparam logic signed [ACC_W-1:0] ACC_LO = ACC_W'(RES_MIN);

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A = 2'd0,
        CFG_SHARED = 2'd1,
        CFG_COLS_B = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic start;
        logic we_a;
        logic we_b;
        logic issue;
        logic publish;
    } t_ctrl_cmd;

    typedef struct packed {
        logic is_compute;
        logic idx_err;
        logic load_a_ok;
        logic load_b_ok;
        logic k_done;
        logic pipe_empty;
    } t_dp_stat;

    function automatic logic signed [RES_W-1:0] sat_res(input logic signed [ACC_W-1:0] a);
        logic signed [RES_W-1:0] r;
        if (a > ACC_HI) begin
            r = RES_W'(RES_MAX);
        end else if (a < ACC_LO) begin
            r = RES_W'(RES_MIN);
        end else begin
            r = RES_W'(a);
        end
        return r;
    endfunction

endpackage

@@ hdl/mme_cmd_if.sv @@
// Command channel of the matrix multiply engine: valid/ready and one command beat.
// Depends on mme_pkg.
interface mme_cmd_if;
    logic                               valid;
    logic                               ready;
    logic [mme_pkg::CMD_W-1:0]          command;
    logic [mme_pkg::POS_W-1:0]          row;
    logic [mme_pkg::POS_W-1:0]          col;
    logic signed [mme_pkg::VAL_W-1:0]   value;

    modport source (output valid, command, row, col, value, input ready);
    modport sink   (input valid, command, row, col, value, output ready);
endinterface

@@ hdl/mme_res_if.sv @@
// Result channel of the matrix multiply engine: valid/ready and one result beat.
// Depends on mme_pkg.
interface mme_res_if;
    logic                               valid;
    logic                               ready;
    logic signed [mme_pkg::RES_W-1:0]   result_value;
    logic                               index_error;

    modport source (output valid, result_value, index_error, input ready);
    modport sink   (input valid, result_value, index_error, output ready);
endinterface

@@ hdl/mme_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mme_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/mme_datapath.sv @@
// Datapath of the matrix multiply engine: size registers, element stores,
// multiply-accumulate pipeline and result register. Depends on mme_pkg, mme_ram.
module mme_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [mme_pkg::CFG_W-1:0]           i_cfg_data,
    input  logic [mme_pkg::CMD_W-1:0]           i_command,
    input  logic [mme_pkg::POS_W-1:0]           i_row,
    input  logic [mme_pkg::POS_W-1:0]           i_col,
    input  logic signed [mme_pkg::VAL_W-1:0]    i_value,
    input  mme_pkg::t_ctrl_cmd                  i_ctl,
    output mme_pkg::t_dp_stat                   o_stat,
    output logic signed [mme_pkg::RES_W-1:0]    o_result_value,
    output logic                                o_index_error
);
    logic [mme_pkg::CFG_W-1:0]          r_rows, r_shared, r_cols;
    logic [mme_pkg::CNT_W-1:0]          nr, ns, nc;
    logic [mme_pkg::IDX_W-1:0]          r_row, r_col;
    logic                               r_err;
    logic [mme_pkg::CNT_W-1:0]          r_k;
    logic                               r_rd_v, r_mul_v;
    logic signed [mme_pkg::PROD_W-1:0]  r_prod;
    logic signed [mme_pkg::ACC_W-1:0]   r_acc;
    logic signed [mme_pkg::RES_W-1:0]   r_res;
    logic                               r_res_err;
    logic [mme_pkg::VAL_W-1:0]          rd_a, rd_b;
    logic [mme_pkg::ADDR_W-1:0]         waddr, raddr_a, raddr_b;
    logic                               row_lt_nr, col_lt_nc, row_lt_ns, col_lt_ns;

    function automatic logic [mme_pkg::CNT_W-1:0] eff(input logic [mme_pkg::CFG_W-1:0] v);
        logic [mme_pkg::CNT_W-1:0] e;
        if (v > mme_pkg::MAX_DIM) begin
            e = mme_pkg::CNT_W'(mme_pkg::MAX_DIM);
        end else begin
            e = mme_pkg::CNT_W'(v);
        end
        return e;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows   <= mme_pkg::CFG_RESET;
            r_shared <= mme_pkg::CFG_RESET;
            r_cols   <= mme_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mme_pkg::CFG_ROWS_A: begin
                    r_rows <= i_cfg_data;
                end
                mme_pkg::CFG_SHARED: begin
                    r_shared <= i_cfg_data;
                end
                mme_pkg::CFG_COLS_B: begin
                    r_cols <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign nr = eff(r_rows);
    assign ns = eff(r_shared);
    assign nc = eff(r_cols);

    assign row_lt_nr = ({1'b0, i_row} < (mme_pkg::POS_W + 1)'(nr));
    assign col_lt_nc = ({1'b0, i_col} < (mme_pkg::POS_W + 1)'(nc));
    assign row_lt_ns = ({1'b0, i_row} < (mme_pkg::POS_W + 1)'(ns));
    assign col_lt_ns = ({1'b0, i_col} < (mme_pkg::POS_W + 1)'(ns));

    always_comb begin
        o_stat.is_compute = 1'b0;
        o_stat.load_a_ok  = 1'b0;
        o_stat.load_b_ok  = 1'b0;
        case (i_command)
            mme_pkg::CMD_LOAD_A: begin
                o_stat.load_a_ok = row_lt_nr && col_lt_ns;
            end
            mme_pkg::CMD_LOAD_B: begin
                o_stat.load_b_ok = row_lt_ns && col_lt_nc;
            end
            mme_pkg::CMD_COMPUTE: begin
                o_stat.is_compute = 1'b1;
            end
            default: begin
            end
        endcase
        o_stat.idx_err    = !(row_lt_nr && col_lt_nc);
        o_stat.k_done     = (r_k == ns);
        o_stat.pipe_empty = !r_rd_v && !r_mul_v;
    end

    assign waddr   = {mme_pkg::IDX_W'(i_row), mme_pkg::IDX_W'(i_col)};
    assign raddr_a = {r_row, r_k[mme_pkg::IDX_W-1:0]};
    assign raddr_b = {r_k[mme_pkg::IDX_W-1:0], r_col};

    mme_ram #(.WIDTH(mme_pkg::VAL_W), .DEPTH(mme_pkg::DEPTH)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (i_ctl.we_a),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr_a),
        .o_rdata (rd_a)
    );

    mme_ram #(.WIDTH(mme_pkg::VAL_W), .DEPTH(mme_pkg::DEPTH)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (i_ctl.we_b),
        .i_waddr (waddr),
        .i_wdata (i_value),
        .i_raddr (raddr_b),
        .o_rdata (rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v  <= 1'b0;
            r_mul_v <= 1'b0;
        end else begin
            r_rd_v  <= i_ctl.issue;
            r_mul_v <= r_rd_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_row <= mme_pkg::IDX_W'(i_row);
            r_col <= mme_pkg::IDX_W'(i_col);
            r_err <= o_stat.idx_err;
            r_k   <= '0;
        end else if (i_ctl.issue) begin
            r_k <= r_k + mme_pkg::CNT_W'(1);
        end
        r_prod <= $signed(rd_a) * $signed(rd_b);
        if (i_ctl.start) begin
            r_acc <= '0;
        end else if (r_mul_v) begin
            r_acc <= r_acc + mme_pkg::ACC_W'(r_prod);
        end
        if (i_ctl.publish) begin
            r_res     <= mme_pkg::sat_res(r_acc);
            r_res_err <= r_err;
        end
    end

    assign o_result_value = r_res;
    assign o_index_error  = r_res_err;
endmodule

@@ hdl/mme_ctrl.sv @@
// Controller of the matrix multiply engine: command handshake, compute sequencing
// and result valid. Depends on mme_pkg.
module mme_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    output logic                o_cmd_ready,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    input  mme_pkg::t_dp_stat   i_stat,
    output mme_pkg::t_ctrl_cmd  o_ctl
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RUN   = 4'b0010,
        S_DRAIN = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_res_valid, n_res_valid;
    logic   accept;

    assign o_cmd_ready = (r_state == S_IDLE);
    assign accept      = i_cmd_valid && o_cmd_ready;

    always_comb begin
        n_state       = r_state;
        o_ctl.start   = 1'b0;
        o_ctl.we_a    = accept && i_stat.load_a_ok;
        o_ctl.we_b    = accept && i_stat.load_b_ok;
        o_ctl.issue   = 1'b0;
        o_ctl.publish = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept && i_stat.is_compute) begin
                    o_ctl.start = 1'b1;
                    n_state     = i_stat.idx_err ? S_DONE : S_RUN;
                end
            end
            S_RUN: begin
                if (i_stat.k_done) begin
                    n_state = S_DRAIN;
                end else begin
                    o_ctl.issue = 1'b1;
                end
            end
            S_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_res_valid || i_res_ready) begin
                    o_ctl.publish = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (o_ctl.publish) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

    assign o_res_valid = r_res_valid;
endmodule

@@ hdl/matrix_multiply_engine_unit.sv @@
// Top level of the matrix multiply engine: controller, datapath and channels.
// Depends on mme_pkg, mme_cmd_if, mme_res_if, mme_ctrl, mme_datapath.
//
// Usage:
//   i_cmd carries one command per beat: load A element, load B element or
//   compute one element of X = A * B. o_res carries one beat per compute:
//   the Q15.22 dot product and an index error flag (value zero on error).
//   The size registers are written through i_cfg_we / i_cfg_idx / i_cfg_data
//   while the engine is idle; a size above 64 acts as 64.
//   A load gives no result beat. A compute holds i_cmd off while the
//   single multiply-accumulate walks the shared dimension with one read of
//   each element store per cycle (no walk when the index is out of range).
//   The result sits in an output register; the next command is taken while
//   it waits. A stalled receiver holds a finished compute until the result
//   register frees up, which then holds i_cmd off.
//   Reset clears the handshake state and sets all sizes to 64; the element
//   stores are not cleared and must be loaded before they are used.
module matrix_multiply_engine_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mme_cmd_if.sink                         i_cmd,
    mme_res_if.source                       o_res,
    input  logic                            i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mme_pkg::CFG_W-1:0]       i_cfg_data
);
    mme_pkg::t_ctrl_cmd ctl;
    mme_pkg::t_dp_stat  stat;

    mme_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (i_cmd.valid),
        .o_cmd_ready (i_cmd.ready),
        .o_res_valid (o_res.valid),
        .i_res_ready (o_res.ready),
        .i_stat      (stat),
        .o_ctl       (ctl)
    );

    mme_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_cmd.command),
        .i_row          (i_cmd.row),
        .i_col          (i_cmd.col),
        .i_value        (i_cmd.value),
        .i_ctl          (ctl),
        .o_stat         (stat),
        .o_result_value (o_res.result_value),
        .o_index_error  (o_res.index_error)
    );
endmodule

@@ tb/mme_checker.sv @@
// Scoreboard for the matrix multiply engine: mirrors the size registers and both
// element stores, predicts every result beat and compares it with the result channel.
// Depends on mme_pkg, mme_cmd_if and mme_res_if.
module mme_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    mme_cmd_if                              i_cmd,
    mme_res_if                              i_res,
    input  logic                            i_cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [mme_pkg::CFG_W-1:0]       i_cfg_data,
    output int                              o_errors,
    output int                              o_pending
);
    import mme_pkg::*;

    typedef struct packed {
        logic signed [RES_W-1:0] dot;
        logic                    index_error;
    } t_product;

    logic [VAL_W-1:0] a_elems [DEPTH];
    logic [VAL_W-1:0] b_elems [DEPTH];
    logic [CFG_W-1:0] rows_a;
    logic [CFG_W-1:0] shared;
    logic [CFG_W-1:0] cols_b;
    t_product         product_q [$];
    t_product         want;
    int               errors = 0;

    assign o_errors = errors;

    function automatic int clip(input logic [CFG_W-1:0] v);
        return (int'(v) > MAX_DIM) ? MAX_DIM : int'(v);
    endfunction

    function automatic t_product predict_product(input int r, input int c);
        t_product p;
        longint   acc;
        acc = 0;
        p.index_error = 1'b0;
        if (r >= clip(rows_a) || c >= clip(cols_b)) begin
            p.index_error = 1'b1;
        end else begin
            for (int k = 0; k < clip(shared); k++) begin
                acc += longint'($signed(a_elems[r * MAX_DIM + k]))
                     * longint'($signed(b_elems[k * MAX_DIM + c]));
            end
        end
        if (acc > RES_MAX) begin
            acc = RES_MAX;
        end else if (acc < RES_MIN) begin
            acc = RES_MIN;
        end
        p.dot = acc[RES_W-1:0];
        return p;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rows_a <= CFG_RESET;
            shared <= CFG_RESET;
            cols_b <= CFG_RESET;
            product_q.delete();
            o_pending <= 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ROWS_A: rows_a <= i_cfg_data;
                    CFG_SHARED: shared <= i_cfg_data;
                    CFG_COLS_B: cols_b <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.valid && i_cmd.ready) begin
                case (i_cmd.command)
                    CMD_LOAD_A: begin
                        if (i_cmd.row < clip(rows_a) && i_cmd.col < clip(shared)) begin
                            a_elems[i_cmd.row * MAX_DIM + i_cmd.col] <= i_cmd.value;
                        end
                    end
                    CMD_LOAD_B: begin
                        if (i_cmd.row < clip(shared) && i_cmd.col < clip(cols_b)) begin
                            b_elems[i_cmd.row * MAX_DIM + i_cmd.col] <= i_cmd.value;
                        end
                    end
                    CMD_COMPUTE: begin
                        product_q.push_back(predict_product(i_cmd.row, i_cmd.col));
                    end
                    default: ;
                endcase
            end
            if (i_res.valid && i_res.ready) begin
                if (product_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mme_checker: unexpected result beat: value %0d err %0b",
                                 i_res.result_value, i_res.index_error);
                    end
                end else begin
                    want = product_q.pop_front();
                    if (i_res.result_value !== want.dot
                            || i_res.index_error !== want.index_error) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mme_checker: mismatch: expected %0d err %0b, got %0d err %0b",
                                     want.dot, want.index_error,
                                     i_res.result_value, i_res.index_error);
                        end
                    end
                end
            end
            o_pending <= product_q.size();
        end
    end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the matrix multiply engine: clock, reset, size register writes,
// command stimulus and result back-pressure; mme_checker does prediction and compare.
// Depends on mme_pkg, mme_cmd_if, mme_res_if, mme_checker and matrix_multiply_engine_unit.
module tb_top;
    import mme_pkg::*;

    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int DRAIN_CYCLES = MAX_DIM + 8;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;
    int                   errors;
    int                   pending;
    int                   send_idle_pct = 0;
    int                   stall_pct = 0;
    int                   hold_gen = 0;
    int                   hold_ack = 0;
    int                   hold_left = 0;
    int                   cycles = 0;
    int                   sent = 0;
    int                   rows_eff = MAX_DIM;
    int                   shared_eff = MAX_DIM;
    int                   cols_eff = MAX_DIM;
    bit                   a_written [MAX_DIM][MAX_DIM];
    bit                   b_written [MAX_DIM][MAX_DIM];

    mme_cmd_if cmd_ch ();
    mme_res_if res_ch ();

    matrix_multiply_engine_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_ch),
        .o_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mme_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd_ch),
        .i_res      (res_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_top: errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
        end else if (hold_left > 0) begin
            res_ch.ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_gen != hold_ack) begin
            res_ch.ready <= 1'b0;
            hold_ack <= hold_gen;
            hold_left <= HOLD_CYCLES;
        end else begin
            res_ch.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    function automatic int clip(input int v);
        return (v > MAX_DIM) ? MAX_DIM : v;
    endfunction

    function automatic logic [VAL_W-1:0] random_q11();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return '0;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    function automatic int pick_index(input int n);
        int j;
        j = $urandom_range(3);
        if (n > 8 && $urandom_range(3) != 0) begin
            return (j < 2) ? j : n - 4 + j;
        end
        return $urandom_range(n - 1);
    endfunction

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int v);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= CFG_W'(v);
        @(posedge i_clk);
    endtask

    task automatic write_sizes(input int r, input int s, input int c);
        settle();
        write_reg(CFG_ROWS_A, r);
        write_reg(CFG_SHARED, s);
        write_reg(CFG_COLS_B, c);
        cfg_we <= 1'b0;
        rows_eff   = clip(r);
        shared_eff = clip(s);
        cols_eff   = clip(c);
    endtask

    task automatic send(input logic [CMD_W-1:0] op, input int r, input int c,
                        input logic [VAL_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.command <= op;
        cmd_ch.row     <= POS_W'(r);
        cmd_ch.col     <= POS_W'(c);
        cmd_ch.value   <= v;
        do @(posedge i_clk); while (!cmd_ch.ready);
        sent++;
        if (op == CMD_LOAD_A && r < rows_eff && c < shared_eff) begin
            a_written[r][c] = 1'b1;
        end
        if (op == CMD_LOAD_B && r < shared_eff && c < cols_eff) begin
            b_written[r][c] = 1'b1;
        end
    endtask

    // load whatever this dot product still lacks, then ask for it
    task automatic compute_filled(input int r, input int c);
        for (int k = 0; k < shared_eff; k++) begin
            if (!a_written[r][k]) begin
                send(CMD_LOAD_A, r, k, random_q11());
            end
            if (!b_written[k][c]) begin
                send(CMD_LOAD_B, k, c, random_q11());
            end
        end
        send(CMD_COMPUTE, r, c, random_q11());
    endtask

    task automatic noise_item();
        logic [CMD_W-1:0] op;
        int               r;
        int               c;
        op = CMD_W'($urandom_range(3));
        r  = $urandom_range(MAX_DIM - 1);
        c  = $urandom_range(MAX_DIM - 1);
        if (op == CMD_COMPUTE && r < rows_eff && c < cols_eff) begin
            compute_filled(r, c);
        end else begin
            send(op, r, c, random_q11());
        end
    endtask

    task automatic random_items(input int count);
        int stop;
        int pick;
        stop = sent + count;
        while (sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 45 && rows_eff > 0 && cols_eff > 0) begin
                compute_filled(pick_index(rows_eff), pick_index(cols_eff));
            end else if (pick < 65 && rows_eff > 0 && shared_eff > 0) begin
                send(CMD_LOAD_A, pick_index(rows_eff), pick_index(shared_eff), random_q11());
            end else if (pick < 80 && shared_eff > 0 && cols_eff > 0) begin
                send(CMD_LOAD_B, pick_index(shared_eff), pick_index(cols_eff), random_q11());
            end else begin
                noise_item();
            end
        end
    endtask

    initial begin
        cmd_ch.valid   <= 1'b0;
        cmd_ch.command <= CMD_LOAD_A;
        cmd_ch.row     <= '0;
        cmd_ch.col     <= '0;
        cmd_ch.value   <= '0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_ROWS_A;
        cfg_data       <= '0;
        i_rst_n        <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_sizes(64, 2, 64);
        send(CMD_LOAD_A, 0, 0, 16'h8000);
        send(CMD_LOAD_A, 0, 1, 16'h8000);
        send(CMD_LOAD_B, 0, 0, 16'h8000);
        send(CMD_LOAD_B, 1, 0, 16'h8000);
        send(CMD_COMPUTE, 0, 0, 16'h0000);
        send(CMD_LOAD_A, 63, 0, 16'h7FFF);
        send(CMD_LOAD_A, 63, 1, 16'h7FFF);
        send(CMD_LOAD_B, 0, 63, 16'h8000);
        send(CMD_LOAD_B, 1, 63, 16'h7FFF);
        send(CMD_COMPUTE, 63, 63, 16'hFFFF);
        send(CMD_COMPUTE, 0, 63, 16'h0000);
        send(CMD_COMPUTE, 63, 0, 16'h0000);
        send(CMD_LOAD_A, 5, 2, 16'h1234);
        send(CMD_LOAD_B, 2, 5, 16'h4321);
        send(CMD_UNUSED, 63, 63, 16'hFFFF);
        send(CMD_LOAD_A, 0, 1, 16'h0000);
        send(CMD_COMPUTE, 0, 0, 16'h0000);

        write_sizes(1, 1, 1);
        send(CMD_LOAD_A, 0, 1, 16'h5555);
        send(CMD_COMPUTE, 0, 0, 16'h0000);
        send(CMD_COMPUTE, 1, 0, 16'h0000);
        send(CMD_COMPUTE, 0, 63, 16'h0000);
        send(CMD_COMPUTE, 63, 63, 16'hFFFF);

        write_sizes(4, 4, 4);
        hold_gen++;
        random_items(200);

        send_idle_pct = 64;
        write_sizes(64, 64, 64);
        random_items(200);

        send_idle_pct = 0;
        stall_pct = 64;
        write_sizes(127, 3, 100);
        random_items(200);

        send_idle_pct = 9;
        stall_pct = 9;
        write_sizes(0, 5, 3);
        random_items(100);

        write_sizes(5, 0, 6);
        random_items(100);

        write_sizes(1, 1, 1);
        random_items(120);

        send_idle_pct = 0;
        stall_pct = 0;
        write_sizes(3, 64, 2);
        random_items(200);

        send_idle_pct = 9;
        stall_pct = 9;
        write_sizes(16, 7, 9);
        random_items(200);

        send_idle_pct = 64;
        stall_pct = 0;
        write_sizes(64, 1, 64);
        random_items(150);

        settle();
        if (errors == 0 && pending == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
